// ===== rtl/lrfc_pkg.sv =====
package lrfc_pkg;

	localparam int RULE_DEPTH = 64;
	localparam int ADDR_W     = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
	localparam int CNT_W      = $clog2(RULE_DEPTH + 1);

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_EVAL  = 1'b1;

	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;

	typedef enum logic [1:0] {
		KIND_WORD_HASH     = 2'd0,
		KIND_INITIAL_UPPER = 2'd1,
		KIND_PUNCT_CHAR    = 2'd2,
		KIND_NEVER         = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ACT_SET   = 2'd0,
		ACT_CLEAR = 2'd1,
		ACT_NONE  = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		CFG_RULE_COUNT = 2'd0,
		CFG_WORD_MASK  = 2'd1,
		CFG_PUNCT_MASK = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		kind_t       kind;
		action_t     action;
		logic [15:0] mask;
		logic [31:0] arg;
	} rule_t;

	typedef struct packed {
		logic [15:0] flags;
		logic [31:0] hash;
		logic [7:0]  len;
		logic [7:0]  ch;
	} lex_t;

	typedef struct packed {
		logic load;
		logic step;
	} eval_ctl_t;

endpackage

// ===== rtl/lrfc_in_if.sv =====
interface lrfc_in_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [5:0]  rule_index;
	logic [1:0]  rule_kind;
	logic [1:0]  rule_action;
	logic [15:0] rule_mask;
	logic [31:0] rule_argument;
	logic [15:0] lexeme_flags;
	logic [31:0] word_hash;
	logic [7:0]  lexeme_length;
	logic [7:0]  first_char;

	modport source (
		output valid, cmd, rule_index, rule_kind, rule_action, rule_mask, rule_argument,
		output lexeme_flags, word_hash, lexeme_length, first_char,
		input  ready
	);
	modport sink (
		input  valid, cmd, rule_index, rule_kind, rule_action, rule_mask, rule_argument,
		input  lexeme_flags, word_hash, lexeme_length, first_char,
		output ready
	);
endinterface

// ===== rtl/lrfc_out_if.sv =====
interface lrfc_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] result_flags;

	modport source (output valid, result_flags, input ready);
	modport sink (input valid, result_flags, output ready);
endinterface

// ===== rtl/lrfc_cfg_if.sv =====
interface lrfc_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/lrfc_rule_mem.sv =====
module lrfc_rule_mem (
	input  logic                        clk,
	input  logic                        we,
	input  logic [lrfc_pkg::ADDR_W-1:0] waddr,
	input  lrfc_pkg::rule_t             wdata,
	input  logic                        re,
	input  logic [lrfc_pkg::ADDR_W-1:0] raddr,
	output lrfc_pkg::rule_t             rdata
);

	lrfc_pkg::rule_t mem [lrfc_pkg::RULE_DEPTH];
	lrfc_pkg::rule_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/lrfc_rule_eval.sv =====
module lrfc_rule_eval (
	input  logic                 clk,
	input  lrfc_pkg::eval_ctl_t  ctl,
	input  lrfc_pkg::lex_t       lex_in,
	input  lrfc_pkg::rule_t      rule,
	input  logic [15:0]          word_mask,
	input  logic [15:0]          punct_mask,
	output logic [15:0]          result
);

	lrfc_pkg::lex_t lex_q;
	logic [15:0]    acc_q;
	logic           is_word;
	logic           is_punct;
	logic           hit;
	logic [15:0]    acc_next;

	// Matches always look at the flags the lexeme arrived with, not the running result.
	assign is_word  = |(lex_q.flags & word_mask);
	assign is_punct = |(lex_q.flags & punct_mask);

	always_comb begin
		unique case (rule.kind)
			lrfc_pkg::KIND_WORD_HASH:
				hit = is_word && (lex_q.hash == rule.arg);
			lrfc_pkg::KIND_INITIAL_UPPER:
				hit = is_word && (lex_q.len != 8'd0) &&
					(lex_q.ch >= lrfc_pkg::CHAR_UPPER_A) &&
					(lex_q.ch <= lrfc_pkg::CHAR_UPPER_Z);
			lrfc_pkg::KIND_PUNCT_CHAR:
				hit = is_punct && (lex_q.len == 8'd1) && (lex_q.ch == rule.arg[7:0]);
			default:
				hit = 1'b0;
		endcase
	end

	always_comb begin
		acc_next = acc_q;
		if (hit) begin
			unique case (rule.action)
				lrfc_pkg::ACT_SET:   acc_next = acc_q | rule.mask;
				lrfc_pkg::ACT_CLEAR: acc_next = acc_q & ~rule.mask;
				default:             acc_next = acc_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			lex_q <= lex_in;
			acc_q <= lex_in.flags;
		end else if (ctl.step) begin
			acc_q <= acc_next;
		end
	end

	assign result = acc_q;

endmodule

// ===== rtl/lexeme_rule_flag_classifier.sv =====
// Lexeme rule flag classifier.
// Channel lexeme carries two kinds of item. A rule write (cmd 0) stores one
// rule in the table without a result, and the channel stays ready. An
// evaluate item (cmd 1) walks rules 0 .. n-1 in order, where n is rule_count
// capped at the table depth of 64, one rule per cycle through the single read
// port of the rule table, and yields one item on channel result. With n above
// zero the sequencer issues the reads in ST_RUN, applies the last rule read in
// ST_DRAIN and offers the result in ST_OUT; with no rules in use it goes from
// ST_IDLE straight to ST_OUT.
// Channel cfg writes rule_count, word_class_mask and punct_class_mask; it is
// always ready and should only be used while no evaluation is in flight.
// The lexeme channel is not ready while an evaluation runs or while its
// result waits; a stalled receiver simply holds the result, which stays
// stable until taken. Reset clears the sequencer and the configuration
// registers (rule_count 0, word mask 1, punctuation mask 2). The rule table
// is not cleared: an entry must be written before any evaluation reads it.
module lexeme_rule_flag_classifier (
	input  logic      clk,
	input  logic      arst_n,
	lrfc_in_if.sink   lexeme,
	lrfc_out_if.source result,
	lrfc_cfg_if.sink  cfg
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_RUN   = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_OUT   = 4'b1000
	} state_t;

	state_t                       state_q;
	logic [lrfc_pkg::CNT_W-1:0]   ptr_q;
	logic [lrfc_pkg::CNT_W-1:0]   n_q;
	logic [lrfc_pkg::CNT_W-1:0]   n_next;
	logic                         rd_valid_q;
	logic [6:0]                   rule_count_q;
	logic [15:0]                  word_mask_q;
	logic [15:0]                  punct_mask_q;

	logic                         in_fire;
	logic                         wr_fire;
	logic                         ev_fire;
	logic                         last_issue;
	logic                         rd_en;
	lrfc_pkg::rule_t              wr_rule;
	lrfc_pkg::rule_t              rd_rule;
	lrfc_pkg::lex_t               lex_in;
	lrfc_pkg::eval_ctl_t          ctl;

	assign in_fire = lexeme.valid && lexeme.ready;
	assign wr_fire = in_fire && (lexeme.cmd == lrfc_pkg::CMD_WRITE) &&
		(32'(lexeme.rule_index) < 32'(lrfc_pkg::RULE_DEPTH));
	assign ev_fire = in_fire && (lexeme.cmd == lrfc_pkg::CMD_EVAL);

	assign n_next = (32'(rule_count_q) > 32'(lrfc_pkg::RULE_DEPTH)) ?
		lrfc_pkg::CNT_W'(lrfc_pkg::RULE_DEPTH) : lrfc_pkg::CNT_W'(rule_count_q);

	assign rd_en      = (state_q == ST_RUN);
	assign last_issue = rd_en && ((ptr_q + 1'b1) == n_q);

	assign lexeme.ready = (state_q == ST_IDLE);
	assign result.valid = (state_q == ST_OUT);
	assign cfg.ready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_count_q <= 7'd0;
			word_mask_q  <= 16'd1;
			punct_mask_q <= 16'd2;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				lrfc_pkg::CFG_RULE_COUNT: rule_count_q <= cfg.data[6:0];
				lrfc_pkg::CFG_WORD_MASK:  word_mask_q  <= cfg.data;
				lrfc_pkg::CFG_PUNCT_MASK: punct_mask_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ptr_q      <= '0;
			n_q        <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			rd_valid_q <= rd_en;
			unique case (state_q)
				ST_IDLE: begin
					if (ev_fire) begin
						ptr_q   <= '0;
						n_q     <= n_next;
						state_q <= (n_next == '0) ? ST_OUT : ST_RUN;
					end
				end
				ST_RUN: begin
					ptr_q <= ptr_q + 1'b1;
					if (last_issue) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// The last rule read is applied in this cycle.
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (result.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign wr_rule.kind   = lrfc_pkg::kind_t'(lexeme.rule_kind);
	assign wr_rule.action = lrfc_pkg::action_t'(lexeme.rule_action);
	assign wr_rule.mask   = lexeme.rule_mask;
	assign wr_rule.arg    = lexeme.rule_argument;

	assign lex_in.flags = lexeme.lexeme_flags;
	assign lex_in.hash  = lexeme.word_hash;
	assign lex_in.len   = lexeme.lexeme_length;
	assign lex_in.ch    = lexeme.first_char;

	assign ctl.load = ev_fire;
	assign ctl.step = rd_valid_q;

	lrfc_rule_mem u_mem (
		.clk   (clk),
		.we    (wr_fire),
		.waddr (lrfc_pkg::ADDR_W'(lexeme.rule_index)),
		.wdata (wr_rule),
		.re    (rd_en),
		.raddr (ptr_q[lrfc_pkg::ADDR_W-1:0]),
		.rdata (rd_rule)
	);

	lrfc_rule_eval u_eval (
		.clk        (clk),
		.ctl        (ctl),
		.lex_in     (lex_in),
		.rule       (rd_rule),
		.word_mask  (word_mask_q),
		.punct_mask (punct_mask_q),
		.result     (result.result_flags)
	);

	a_no_accept_while_result: assert property (@(posedge clk) disable iff (!arst_n)
		!(lexeme.ready && result.valid))
		else $error("lexeme channel ready while a result is pending");

	a_ptr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (ptr_q < n_q))
		else $error("rule pointer beyond rule count");

	a_step_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_q |-> ((state_q == ST_RUN) || (state_q == ST_DRAIN)))
		else $error("rule applied outside a table walk");

	a_empty_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(ev_fire && (n_next == '0)) |=> result.valid)
		else $error("evaluation with no rules did not give a result at once");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

	localparam int          CLK_HALF      = 5;
	localparam int          SETTLE_CYCLES = lrfc_pkg::RULE_DEPTH + 16;
	localparam int          HOLD_CYCLES   = 300;
	localparam int          QUIET_LIMIT   = 2000;
	localparam int          PHASE_ITEMS   = 180;
	localparam int          PRESSURE_ITEMS = 60;
	localparam logic [1:0]  ACT_SPARE     = 2'd3;
	localparam logic [1:0]  CFG_UNUSED    = 2'd3;
	localparam logic [7:0]  CHAR_DOT      = 8'h2E;
	localparam logic [7:0]  CHAR_COMMA    = 8'h2C;
	localparam logic [7:0]  CHAR_BANG     = 8'h21;
	localparam logic [7:0]  CHAR_LOWER_A  = 8'h61;
	localparam logic [31:0] HASH_PROBE    = 32'hDEAD_BEEF;

	typedef struct {
		logic            cmd;
		logic [5:0]      index;
		lrfc_pkg::kind_t kind;
		logic [1:0]      action;
		logic [15:0]     mask;
		logic [31:0]     arg;
		logic [15:0]     flags;
		logic [31:0]     hash;
		logic [7:0]      len;
		logic [7:0]      ch;
	} lexeme_item_t;

	typedef struct {
		lrfc_pkg::kind_t kind;
		logic [1:0]      action;
		logic [15:0]     mask;
		logic [31:0]     arg;
	} stored_rule_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	lrfc_in_if  lexeme_ch ();
	lrfc_out_if result_ch ();
	lrfc_cfg_if cfg_ch ();

	lexeme_rule_flag_classifier DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.lexeme (lexeme_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// Local copy of the block's state, at its reset values.
	stored_rule_t rule_store [lrfc_pkg::RULE_DEPTH];
	logic [6:0]   rule_count_q = 7'd0;
	logic [15:0]  word_mask_q  = 16'h0001;
	logic [15:0]  punct_mask_q = 16'h0002;
	logic [15:0]  expected_flags [$];

	logic [31:0] hash_pool [8];
	logic [7:0]  punct_pool [4];

	bit idling_on;
	bit hold_req;
	int mismatches;
	int evals_seen;
	int writes_seen;
	int settings_seen;
	int hits_set;
	int hits_clear;
	int hits_idle;

	always #CLK_HALF clk = ~clk;

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $time, what);
		mismatches++;
	endtask

	// Walks the rules in use; matching always looks at the incoming flags.
	function automatic logic [15:0] classify_lexeme(input lexeme_item_t it);
		logic [15:0]  flags_out;
		int           n;
		logic         hit;
		logic         is_word;
		logic         is_punct;
		stored_rule_t r;
		flags_out = it.flags;
		n = (int'(rule_count_q) > lrfc_pkg::RULE_DEPTH) ? lrfc_pkg::RULE_DEPTH :
			int'(rule_count_q);
		is_word = |(it.flags & word_mask_q);
		is_punct = |(it.flags & punct_mask_q);
		for (int i = 0; i < n; i++) begin
			r = rule_store[i];
			case (r.kind)
				lrfc_pkg::KIND_WORD_HASH: hit = is_word && it.hash == r.arg;
				lrfc_pkg::KIND_INITIAL_UPPER: begin
					hit = is_word && it.len != 8'd0 &&
						it.ch >= lrfc_pkg::CHAR_UPPER_A && it.ch <= lrfc_pkg::CHAR_UPPER_Z;
				end
				lrfc_pkg::KIND_PUNCT_CHAR: begin
					hit = is_punct && it.len == 8'd1 && it.ch == r.arg[7:0];
				end
				default: hit = 1'b0;
			endcase
			if (hit) begin
				if (r.action == lrfc_pkg::ACT_SET) begin
					flags_out |= r.mask;
					hits_set++;
				end else if (r.action == lrfc_pkg::ACT_CLEAR) begin
					flags_out &= ~r.mask;
					hits_clear++;
				end else begin
					hits_idle++;
				end
			end
		end
		return flags_out;
	endfunction

	task automatic absorb_item(input lexeme_item_t it);
		if (it.cmd == lrfc_pkg::CMD_WRITE) begin
			rule_store[it.index].kind = it.kind;
			rule_store[it.index].action = it.action;
			rule_store[it.index].mask = it.mask;
			rule_store[it.index].arg = it.arg;
			writes_seen++;
		end else begin
			expected_flags.push_back(classify_lexeme(it));
			evals_seen++;
		end
	endtask

	function automatic lexeme_item_t random_item();
		lexeme_item_t it;
		int           pick;
		it.cmd = ($urandom_range(0, 3) == 0) ? lrfc_pkg::CMD_WRITE : lrfc_pkg::CMD_EVAL;
		it.index = 6'($urandom);
		it.kind = lrfc_pkg::kind_t'($urandom_range(0, 3));
		it.action = 2'($urandom);
		it.mask = 16'($urandom);
		it.arg = $urandom;
		it.flags = 16'($urandom);
		it.hash = $urandom;
		it.len = 8'($urandom);
		it.ch = 8'($urandom);
		if (it.cmd == lrfc_pkg::CMD_WRITE) begin
			pick = $urandom_range(0, 9);
			if (pick < 5) begin
				it.arg = hash_pool[$urandom_range(0, 7)];
			end else if (pick < 8) begin
				it.arg[7:0] = punct_pool[$urandom_range(0, 3)];
			end
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				it.mask = 16'h0000;
			end else if (pick == 1) begin
				it.mask = 16'hFFFF;
			end
			if ($urandom_range(0, 4) != 0) begin
				it.action = $urandom_range(0, 1) ? lrfc_pkg::ACT_CLEAR : lrfc_pkg::ACT_SET;
			end
		end else begin
			pick = $urandom_range(0, 9);
			if (pick < 4) begin
				it.flags |= word_mask_q;
			end else if (pick < 7) begin
				it.flags |= punct_mask_q;
			end else if (pick == 7) begin
				it.flags &= ~(word_mask_q | punct_mask_q);
			end
			if ($urandom_range(0, 9) < 6) begin
				it.hash = hash_pool[$urandom_range(0, 7)];
			end
			pick = $urandom_range(0, 9);
			if (pick < 4) begin
				it.len = 8'd1;
			end else if (pick == 4) begin
				it.len = 8'd0;
			end else if (pick == 5) begin
				it.len = 8'hFF;
			end
			pick = $urandom_range(0, 9);
			if (pick < 3) begin
				it.ch = 8'($urandom_range(lrfc_pkg::CHAR_UPPER_A, lrfc_pkg::CHAR_UPPER_Z));
			end else if (pick < 6) begin
				it.ch = punct_pool[$urandom_range(0, 3)];
			end else if (pick == 6) begin
				it.ch = lrfc_pkg::CHAR_UPPER_A - 8'd1;
			end else if (pick == 7) begin
				it.ch = lrfc_pkg::CHAR_UPPER_Z + 8'd1;
			end
		end
		return it;
	endfunction

	function automatic lexeme_item_t make_rule(input logic [5:0] idx,
			input lrfc_pkg::kind_t kind, input logic [1:0] action, input logic [15:0] mask,
			input logic [31:0] arg);
		lexeme_item_t it;
		it = random_item();
		it.cmd = lrfc_pkg::CMD_WRITE;
		it.index = idx;
		it.kind = kind;
		it.action = action;
		it.mask = mask;
		it.arg = arg;
		return it;
	endfunction

	function automatic lexeme_item_t make_eval(input logic [15:0] flags,
			input logic [31:0] hash, input logic [7:0] len, input logic [7:0] ch);
		lexeme_item_t it;
		it = random_item();
		it.cmd = lrfc_pkg::CMD_EVAL;
		it.flags = flags;
		it.hash = hash;
		it.len = len;
		it.ch = ch;
		return it;
	endfunction

	function automatic logic [15:0] random_class_mask();
		logic [15:0] m;
		m = 16'h0001 << $urandom_range(0, 15);
		if ($urandom_range(0, 3) == 0) begin
			m |= 16'($urandom);
		end
		return m;
	endfunction

	// Called just after a falling edge; returns just after a falling edge with
	// valid still high, so back-to-back items need no second assignment.
	task automatic send_item(input lexeme_item_t it);
		if (idling_on && $urandom_range(0, 5) == 0) begin
			lexeme_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		lexeme_ch.valid <= 1'b1;
		lexeme_ch.cmd <= it.cmd;
		lexeme_ch.rule_index <= it.index;
		lexeme_ch.rule_kind <= it.kind;
		lexeme_ch.rule_action <= it.action;
		lexeme_ch.rule_mask <= it.mask;
		lexeme_ch.rule_argument <= it.arg;
		lexeme_ch.lexeme_flags <= it.flags;
		lexeme_ch.word_hash <= it.hash;
		lexeme_ch.lexeme_length <= it.len;
		lexeme_ch.first_char <= it.ch;
		do @(posedge clk); while (lexeme_ch.ready !== 1'b1);
		absorb_item(it);
		@(negedge clk);
	endtask

	task automatic write_register(input logic [1:0] idx, input logic [15:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		case (idx)
			lrfc_pkg::CFG_RULE_COUNT: rule_count_q = data[6:0];
			lrfc_pkg::CFG_WORD_MASK:  word_mask_q = data;
			lrfc_pkg::CFG_PUNCT_MASK: punct_mask_q = data;
			default: ;
		endcase
		@(negedge clk);
	endtask

	// A rule write gives no result and is stored as soon as it is taken, so the
	// block is idle once the queue empties; the pause covers a full walk of the table.
	task automatic drain_results();
		lexeme_ch.valid <= 1'b0;
		while (expected_flags.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic apply_settings(input logic [15:0] count_data, input logic [15:0] word_data,
			input logic [15:0] punct_data);
		drain_results();
		write_register(lrfc_pkg::CFG_RULE_COUNT, count_data);
		write_register(lrfc_pkg::CFG_WORD_MASK, word_data);
		write_register(lrfc_pkg::CFG_PUNCT_MASK, punct_data);
		write_register(CFG_UNUSED, 16'($urandom));
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
		settings_seen++;
	endtask

	task automatic test_empty_table();
		send_item(make_eval(16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF));
		send_item(make_eval(16'h0000, 32'h0000_0000, 8'h00, 8'h00));
	endtask

	task automatic test_directed_rules();
		send_item(make_rule(6'd0, lrfc_pkg::KIND_WORD_HASH, lrfc_pkg::ACT_SET, 16'h0100,
			HASH_PROBE));
		send_item(make_rule(6'd1, lrfc_pkg::KIND_INITIAL_UPPER, lrfc_pkg::ACT_SET, 16'h0200,
			32'h0));
		// Upper bits of the argument must not matter for a punctuation rule.
		send_item(make_rule(6'd2, lrfc_pkg::KIND_PUNCT_CHAR, lrfc_pkg::ACT_SET, 16'h0400,
			{24'hFFFFFF, CHAR_DOT}));
		send_item(make_rule(6'd3, lrfc_pkg::KIND_NEVER, lrfc_pkg::ACT_SET, 16'hFFFF, 32'h0));
		send_item(make_rule(6'd4, lrfc_pkg::KIND_WORD_HASH, lrfc_pkg::ACT_CLEAR, 16'h0100,
			HASH_PROBE));
		send_item(make_rule(6'd5, lrfc_pkg::KIND_WORD_HASH, lrfc_pkg::ACT_NONE, 16'hFFFF,
			32'h0));
		send_item(make_rule(6'd6, lrfc_pkg::KIND_INITIAL_UPPER, ACT_SPARE, 16'hFFFF, 32'h0));
		// Clears the punctuation flag itself; later matches still see it.
		send_item(make_rule(6'd7, lrfc_pkg::KIND_PUNCT_CHAR, lrfc_pkg::ACT_CLEAR, 16'h0002,
			{24'h0, CHAR_DOT}));
		apply_settings(16'd8, 16'h0001, 16'h0002);
		send_item(make_eval(16'h0001, HASH_PROBE, 8'd3, CHAR_LOWER_A));
		send_item(make_eval(16'h0001, 32'h0, 8'd5, lrfc_pkg::CHAR_UPPER_A));
		send_item(make_eval(16'h0001, 32'h1, 8'd1, lrfc_pkg::CHAR_UPPER_Z));
		send_item(make_eval(16'h0001, 32'h1, 8'd1, lrfc_pkg::CHAR_UPPER_A - 8'd1));
		send_item(make_eval(16'h0001, 32'h1, 8'd1, lrfc_pkg::CHAR_UPPER_Z + 8'd1));
		send_item(make_eval(16'h0001, 32'h1, 8'd0, lrfc_pkg::CHAR_UPPER_A));
		send_item(make_eval(16'h0002, 32'h1, 8'd1, CHAR_DOT));
		send_item(make_eval(16'h0002, 32'h1, 8'd2, CHAR_DOT));
		send_item(make_eval(16'h0003, HASH_PROBE, 8'd1, CHAR_DOT));
		send_item(make_eval(16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF));
		send_item(make_eval(16'h0000, HASH_PROBE, 8'd1, CHAR_DOT));
		apply_settings(16'd8, 16'h0000, 16'hFFFF);
		send_item(make_eval(16'hFFFF, HASH_PROBE, 8'd1, CHAR_DOT));
		send_item(make_eval(16'h8000, 32'h0, 8'd1, lrfc_pkg::CHAR_UPPER_A));
	endtask

	// Every entry gets written before any setting walks beyond the directed rules.
	task automatic test_table_fill();
		lexeme_item_t it;
		for (int i = 0; i < lrfc_pkg::RULE_DEPTH; i++) begin
			do it = random_item(); while (it.cmd != lrfc_pkg::CMD_WRITE);
			it.index = 6'(i);
			send_item(it);
		end
	endtask

	task automatic test_random_phases();
		for (int p = 0; p < 7; p++) begin
			idling_on = (p != 2);
			case (p)
				0: apply_settings(16'd64, 16'h0001, 16'h0002);
				1: apply_settings(16'h00FF, 16'hFFFF, 16'hFFFF);
				2: apply_settings(16'd0, 16'h0000, 16'h0000);
				3: apply_settings(16'd1, random_class_mask(), random_class_mask());
				4: apply_settings(16'hFFC1, random_class_mask(), random_class_mask());
				default: begin
					apply_settings(16'($urandom_range(0, lrfc_pkg::RULE_DEPTH)),
						random_class_mask(), random_class_mask());
				end
			endcase
			repeat (PHASE_ITEMS) send_item(random_item());
		end
		idling_on = 1'b1;
	endtask

	// The receiver holds off while the sender keeps offering, so the block
	// ends up holding a result and refusing further items.
	task automatic test_receiver_backpressure();
		apply_settings(16'd64, random_class_mask(), random_class_mask());
		idling_on = 1'b0;
		hold_req = 1'b1;
		repeat (PRESSURE_ITEMS) send_item(random_item());
		idling_on = 1'b1;
	endtask

	task automatic test_unthrottled();
		apply_settings(16'd64, random_class_mask(), random_class_mask());
		idling_on = 1'b0;
		repeat (PHASE_ITEMS) send_item(random_item());
	endtask

	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				stall_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end else if (stall_left == 0 && idling_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 17);
			end
			if (stall_left > 0) begin
				result_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	initial begin : result_check
		logic [15:0] want;
		forever begin
			@(posedge clk);
			if (arst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
				if (expected_flags.size() == 0) begin
					report_mismatch($sformatf("flags %04h with no lexeme pending",
						result_ch.result_flags));
				end else begin
					want = expected_flags.pop_front();
					if (result_ch.result_flags !== want) begin
						report_mismatch($sformatf("result_flags %04h, expected %04h",
							result_ch.result_flags, want));
					end
				end
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (lexeme_ch.valid && lexeme_ch.ready === 1'b1) ||
					(result_ch.valid === 1'b1 && result_ch.ready) ||
					(cfg_ch.valid && cfg_ch.ready === 1'b1)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("No handshake for %0d cycles, %0d results outstanding", QUIET_LIMIT,
			expected_flags.size());
		$display("simulation failed");
		$finish;
	end

	initial begin : stimulus
		lexeme_ch.valid = 1'b0;
		lexeme_ch.cmd = lrfc_pkg::CMD_WRITE;
		lexeme_ch.rule_index = '0;
		lexeme_ch.rule_kind = lrfc_pkg::KIND_WORD_HASH;
		lexeme_ch.rule_action = lrfc_pkg::ACT_SET;
		lexeme_ch.rule_mask = '0;
		lexeme_ch.rule_argument = '0;
		lexeme_ch.lexeme_flags = '0;
		lexeme_ch.word_hash = '0;
		lexeme_ch.lexeme_length = '0;
		lexeme_ch.first_char = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = lrfc_pkg::CFG_RULE_COUNT;
		cfg_ch.data = '0;
		idling_on = 1'b1;
		hold_req = 1'b0;
		mismatches = 0;
		evals_seen = 0;
		writes_seen = 0;
		settings_seen = 0;
		hits_set = 0;
		hits_clear = 0;
		hits_idle = 0;
		foreach (hash_pool[i]) hash_pool[i] = $urandom;
		punct_pool = '{CHAR_DOT, CHAR_COMMA, CHAR_BANG, 8'($urandom)};

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_empty_table();
		test_directed_rules();
		test_table_fill();
		test_random_phases();
		test_receiver_backpressure();
		test_unthrottled();
		drain_results();

		$display("Run covered %0d lexeme evaluations and %0d rule writes over %0d settings.",
			evals_seen, writes_seen, settings_seen);
		$display("Rule hits: %0d set, %0d clear, %0d with no effect; %0d mismatches.",
			hits_set, hits_clear, hits_idle, mismatches);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ===== lexeme_rule_flag_classifier.f =====
rtl/lrfc_pkg.sv
rtl/lrfc_in_if.sv
rtl/lrfc_out_if.sv
rtl/lrfc_cfg_if.sv
rtl/lrfc_rule_mem.sv
rtl/lrfc_rule_eval.sv
rtl/lexeme_rule_flag_classifier.sv
bench/tb_top.sv
